[rtl/bfsp_pkg.sv]
`default_nettype none
package bfsp_pkg;

	// stream widths
	localparam int S_DATA_W   = 48;
	localparam int M_DATA_W   = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// slave tdata layout
	localparam int IDX_LSB   = 0;
	localparam int SRC_LSB   = 8;
	localparam int DST_LSB   = 14;
	localparam int WGT_LSB   = 20;
	localparam int START_LSB = 36;

	// master tdata layout
	localparam int VTX_LSB   = 0;
	localparam int DIST_LSB  = 6;
	localparam int REACH_BIT = 38;

	localparam int VTX_W  = 6;
	localparam int WGT_W  = 16;
	localparam int DIST_W = 32;
	localparam int EDGE_W = 2 * VTX_W + WGT_W;
	localparam int ENTRY_W = DIST_W + 1;

	// request kinds on s_tuser
	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_RUN  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT   = 2'd1;

	localparam logic [DIST_W-1:0] INT_MAX = 32'h7FFF_FFFF;
	localparam logic [DIST_W-1:0] INT_MIN = 32'h8000_0000;

	typedef logic [EDGE_W-1:0]  edge_word_t;
	typedef logic [ENTRY_W-1:0] dist_entry_t;

endpackage
`default_nettype wire

[rtl/bellman_ford_shortest_paths_core.sv]
`default_nettype none
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------------------------
// s_*       | in        | s_tvalid/s_tready  | tuser: req_type; tdata: edge index/src/dst/
//           |           |                    |   weight/start vertex
// m_*       | out       | m_tvalid/m_tready  | tuser: negative_cycle; tlast: last;
//           |           |                    |   tdata: vertex/distance/reachable
// cfg_*     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (register write)
//
// Sequence: an edge load is a single store write. A run sets up all MAX_VERTS entries
//   of the distance store, relaxes each edge in each of vertex_count passes plus the
//   negative-cycle sweep, then returns one result per vertex, or a single result if a
//   negative cycle was found; m_tready stalls slow the output.
// Edges are relaxed one at a time by a read-modify-write loop on the distance store
//   (read edge, read both endpoints, add/compare/write back).
// Reset: control registers clear; edge and distance stores are not cleared.
// Stalls: s_tready is high only while idle; the result register lets the last
//   result of a run wait while the next transaction is taken.
module bellman_ford_shortest_paths_core
	import bfsp_pkg::*;
#(
	parameter int MAX_VERTS      = 64,
	parameter int MAX_EDGE_SLOTS = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// slave stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,   // [7:0] edge_index, [13:8] edge_src,
	                                              // [19:14] edge_dst, [35:20] edge_weight,
	                                              // [41:36] run_root, [47:42] zero
	input  wire logic                  s_tuser,   // [0] req_type
	// master stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_DATA_W-1:0]        m_tdata,   // [5:0] vertex, [37:6] distance,
	                                              // [38] reachable, [39] zero
	output logic                       m_tuser,   // [0] negative_cycle
	output logic                       m_tlast,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int VAW = $clog2(MAX_VERTS);
	localparam int VCW = $clog2(MAX_VERTS + 1);
	localparam int EAW = (MAX_EDGE_SLOTS > 1) ? $clog2(MAX_EDGE_SLOTS) : 1;
	localparam int ECW = $clog2(MAX_EDGE_SLOTS + 1);
	localparam int NW  = (ECW > 9) ? ECW : 9;
	localparam int IW  = (EAW > 8) ? EAW : 8;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_INIT    = 3'd1;
	localparam logic [2:0] ST_RELAX_A = 3'd2;
	localparam logic [2:0] ST_RELAX_B = 3'd3;
	localparam logic [2:0] ST_OUT_RD  = 3'd4;
	localparam logic [2:0] ST_OUT_LD  = 3'd5;
	localparam logic [2:0] ST_OUT_CYC = 3'd6;

	// control state
	logic [2:0]      state_q;
	logic [6:0]      vcnt_q;
	logic [8:0]      ecnt_q;
	logic [VTX_W-1:0] start_q;
	logic [VAW-1:0]  init_idx_q;
	logic [VAW-1:0]  out_idx_q;
	logic [VCW-1:0]  pass_q;
	logic [ECW-1:0]  ptr_q;
	logic            check_q;
	logic            cyc_q;

	// output register
	logic                m_valid_q;
	logic [VTX_W-1:0]    m_vtx_q;
	logic [DIST_W-1:0]   m_dist_q;
	logic                m_reach_q;
	logic                m_neg_q;
	logic                m_last_q;

	// memories
	edge_word_t  edge_mem [MAX_EDGE_SLOTS];
	dist_entry_t dist_mem [MAX_VERTS];
	edge_word_t  edge_rd_q;
	dist_entry_t dist_a_q;
	dist_entry_t dist_b_q;

	// effective sizes: zero vertices count as one, both clipped to the store depth
	logic [VCW-1:0] nv;
	logic [NW-1:0]  ne_w;
	logic [ECW-1:0] ne;

	always_comb begin
		if (vcnt_q == 7'd0)
			nv = VCW'(1);
		else if (vcnt_q > 7'(MAX_VERTS))
			nv = VCW'(MAX_VERTS);
		else
			nv = VCW'(vcnt_q);
		ne_w = (NW'(ecnt_q) > NW'(MAX_EDGE_SLOTS)) ? NW'(MAX_EDGE_SLOTS) : NW'(ecnt_q);
		ne   = ne_w[ECW-1:0];
	end

	// input handshake
	logic s_acc;
	logic m_free;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_free   = !m_valid_q || m_tready;

	// edge store write (loads are taken only while idle)
	logic [IW-1:0]  load_idx;
	logic           edge_we;
	logic [EAW-1:0] edge_waddr;
	edge_word_t     edge_wdata;

	assign load_idx   = IW'(s_tdata[IDX_LSB +: 8]);
	assign edge_we    = s_acc && (s_tuser == REQ_EDGE) && (32'(load_idx) < MAX_EDGE_SLOTS);
	assign edge_waddr = load_idx[EAW-1:0];
	assign edge_wdata = {s_tdata[SRC_LSB +: VTX_W], s_tdata[DST_LSB +: VTX_W],
	                     s_tdata[WGT_LSB +: WGT_W]};

	// edge pointer walk; the next edge is fetched during the write-back cycle
	logic [ECW-1:0] ptr_inc;
	logic [ECW-1:0] ptr_next;
	logic           last_edge;
	logic [ECW-1:0] edge_raddr_full;
	logic [EAW-1:0] edge_raddr;

	assign ptr_inc   = ptr_q + 1'b1;
	assign last_edge = (ptr_inc == ne);
	assign ptr_next  = last_edge ? '0 : ptr_inc;
	assign edge_raddr_full = (state_q == ST_RELAX_B) ? ptr_next : ptr_q;
	assign edge_raddr = edge_raddr_full[EAW-1:0];

	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[edge_waddr] <= edge_wdata;
		edge_rd_q <= edge_mem[edge_raddr];
	end

	// current edge fields
	logic [VTX_W-1:0] eu;
	logic [VTX_W-1:0] ev;
	logic [WGT_W-1:0] ew;
	assign eu = edge_rd_q[EDGE_W-1 -: VTX_W];
	assign ev = edge_rd_q[WGT_W +: VTX_W];
	assign ew = edge_rd_q[WGT_W-1:0];

	// relaxation: candidate from the source, compared against the destination
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] cand;
	logic              edge_ok;
	logic              lower;

	always_comb begin
		sum = {dist_a_q[DIST_W-1], dist_a_q[DIST_W-1:0]}
		    + {{(DIST_W + 1 - WGT_W){ew[WGT_W-1]}}, ew};
		if (sum[DIST_W] != sum[DIST_W-1])
			cand = sum[DIST_W] ? INT_MIN : INT_MAX;
		else
			cand = sum[DIST_W-1:0];
		edge_ok = (7'(eu) < 7'(nv)) && (7'(ev) < 7'(nv)) && dist_a_q[DIST_W];
		lower   = edge_ok && (!dist_b_q[DIST_W] ||
		          ($signed(cand) < $signed(dist_b_q[DIST_W-1:0])));
	end

	// distance store: one write port, two read ports
	logic           start_ok;
	logic           dist_we;
	logic [VAW-1:0] dist_waddr;
	dist_entry_t    dist_wdata;
	logic [VAW-1:0] dist_raddr_a;
	logic [VAW-1:0] dist_raddr_b;

	assign start_ok = (7'(start_q) < 7'(nv));

	always_comb begin
		if (state_q == ST_INIT) begin
			dist_we    = 1'b1;
			dist_waddr = init_idx_q;
			dist_wdata = {start_ok && (7'(init_idx_q) == 7'(start_q)), {DIST_W{1'b0}}};
		end else begin
			dist_we    = (state_q == ST_RELAX_B) && !check_q && lower;
			dist_waddr = VAW'(ev);
			dist_wdata = {1'b1, cand};
		end
		if (state_q inside {ST_OUT_RD, ST_OUT_LD})
			dist_raddr_a = out_idx_q;
		else
			dist_raddr_a = VAW'(eu);
		dist_raddr_b = VAW'(ev);
	end

	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[dist_waddr] <= dist_wdata;
		dist_a_q <= dist_mem[dist_raddr_a];
		dist_b_q <= dist_mem[dist_raddr_b];
	end

	logic out_last;
	assign out_last = ((VCW'(out_idx_q) + 1'b1) == nv);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= 7'd1;
			ecnt_q <= 9'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vcnt_q <= cfg_data[6:0];
				REG_EDGE_COUNT:   ecnt_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= '0;
			init_idx_q <= '0;
			out_idx_q  <= '0;
			pass_q     <= '0;
			ptr_q      <= '0;
			check_q    <= 1'b0;
			cyc_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc && s_tuser == REQ_RUN) begin
						start_q    <= s_tdata[START_LSB +: VTX_W];
						init_idx_q <= '0;
						out_idx_q  <= '0;
						pass_q     <= '0;
						ptr_q      <= '0;
						check_q    <= 1'b0;
						cyc_q      <= 1'b0;
						state_q    <= ST_INIT;
					end
				end
				ST_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (init_idx_q == VAW'(MAX_VERTS - 1))
						state_q <= (ne == '0) ? ST_OUT_RD : ST_RELAX_A;
				end
				ST_RELAX_A: state_q <= ST_RELAX_B;
				ST_RELAX_B: begin
					ptr_q <= ptr_next;
					cyc_q <= cyc_q || (check_q && lower);
					if (!last_edge)
						state_q <= ST_RELAX_A;
					else if (check_q)
						state_q <= (cyc_q || lower) ? ST_OUT_CYC : ST_OUT_RD;
					else begin
						state_q <= ST_RELAX_A;
						if ((pass_q + 1'b1) == nv)
							check_q <= 1'b1;
						else
							pass_q <= pass_q + 1'b1;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_LD;
				ST_OUT_LD: begin
					if (m_free) begin
						if (out_last) begin
							pass_q  <= '0;
							check_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 1'b1;
							state_q   <= ST_OUT_RD;
						end
					end
				end
				ST_OUT_CYC: begin
					if (m_free) begin
						pass_q  <= '0;
						check_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	logic m_load;
	assign m_load = m_free && (state_q inside {ST_OUT_LD, ST_OUT_CYC});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (m_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (m_load) begin
			if (state_q == ST_OUT_CYC) begin
				m_vtx_q   <= '0;
				m_dist_q  <= '0;
				m_reach_q <= 1'b0;
				m_neg_q   <= 1'b1;
				m_last_q  <= 1'b1;
			end else begin
				m_vtx_q   <= VTX_W'(out_idx_q);
				m_dist_q  <= dist_a_q[DIST_W] ? dist_a_q[DIST_W-1:0] : INT_MAX;
				m_reach_q <= dist_a_q[DIST_W];
				m_neg_q   <= 1'b0;
				m_last_q  <= out_last;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_reach_q, m_dist_q, m_vtx_q};
	assign m_tuser  = m_neg_q;
	assign m_tlast  = m_last_q;

endmodule
`default_nettype wire

[rtl/bfsp_checker.sv]
`default_nettype none
module bfsp_port_checker
	import bfsp_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [S_DATA_W-1:0]   s_tdata,
	input wire logic                  s_tuser,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [M_DATA_W-1:0]   m_tdata,
	input wire logic                  m_tuser,
	input wire logic                  m_tlast,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	// a negative-cycle result closes the run on its own
	a_neg_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("negative-cycle result without tlast");

	// and carries vertex 0, distance 0, not reachable
	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("negative-cycle result with nonzero data");

	// an unreachable vertex reports the largest distance
	a_unreach_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && !m_tdata[REACH_BIT] |->
		m_tdata[DIST_LSB +: DIST_W] == INT_MAX)
		else $error("unreachable vertex with finite distance");

	// stalled result holds
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result changed while stalled");

endmodule

bind bellman_ford_shortest_paths_core bfsp_port_checker u_bfsp_checker (.*);
`default_nettype wire
